// File: rtl/core/pfba_pkg.sv
// Package for the paged fixed-block allocator.
// Holds request and status codes and the fixed handle width.
// No dependencies.
package pfba_pkg;

  localparam int HANDLE_W = 10;
  localparam int SIZE_W   = 16;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_PAGES = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 16'd64;

endpackage

// File: rtl/core/paged_fixed_block_allocator_top.sv
// Top level of the paged fixed-block allocator.
// Uses pfba_pkg for codes and widths; holds the page table and link store memories.
//
// The pool holds up to MAX_PAGES pages of BLOCKS_PER_PAGE blocks; a block is named by
// its handle, page * BLOCKS_PER_PAGE + block, truncated to 10 bits on the result port.
// Page 0 is open after reset. One item is worked on at a time and in_stall is high
// while it is in flight. A single compare/add unit walks the open pages one per cycle,
// reading the page table (bump count and free-list head) through a registered memory
// port. An allocate passes over full pages with empty free lists until it finds a
// block or opens a new page; popping a block from a free list adds a link store read.
// A free or query walks to the handle's page, or past the open pages when the
// handle's page is not open, stepping down the handle one page size per cycle. An
// oversized allocate or an unused request type goes straight to the result state.
// The result sits in an output register, so an item can be accepted while the
// previous result is still stalled. The user must write block_size only while the
// block is idle; the block itself does not enforce it. cfg_ready is always high.
// No clearing pass follows reset.
module paged_fixed_block_allocator_top
  import pfba_pkg::*;
#(
  parameter int BLOCKS_PER_PAGE = 64,
  parameter int MAX_PAGES       = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic [SIZE_W-1:0]   in_req_size,
  input  logic [HANDLE_W-1:0] in_handle,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_granted_handle,
  output logic                out_found,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   cfg_data
);

  // Widths follow from the pool geometry. A bump count and a free-list head both
  // need to hold BLOCKS_PER_PAGE itself, which marks a full page or an empty list.
  localparam int BW    = $clog2(BLOCKS_PER_PAGE + 1);
  localparam int PW    = $clog2(MAX_PAGES + 1);
  localparam int PIW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int TOTAL = MAX_PAGES * BLOCKS_PER_PAGE;
  localparam int IW    = $clog2(TOTAL + 1);
  localparam int LAW   = $clog2(TOTAL);
  localparam int CW    = (HANDLE_W > BW) ? HANDLE_W : BW;

  localparam logic [BW-1:0] BPP_B  = BW'(BLOCKS_PER_PAGE);
  localparam logic [CW-1:0] BPP_C  = CW'(BLOCKS_PER_PAGE);
  localparam logic [IW-1:0] BPP_I  = IW'(BLOCKS_PER_PAGE);
  localparam logic [PW-1:0] MAXP_P = PW'(MAX_PAGES);
  localparam logic [BW-1:0] ONE_B  = BW'(1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  typedef struct packed {
    logic [BW-1:0] bump;
    logic [BW-1:0] head;
  } pt_entry_t;

  // Memories: page table and per-block link store.
  pt_entry_t     pt_mem   [MAX_PAGES];
  logic [BW-1:0] link_mem [TOTAL];

  // Control and working registers.
  logic [1:0]          state_r, state_nxt;
  logic [1:0]          req_type_r, req_type_nxt;
  logic [PW-1:0]       p_r, p_nxt;
  logic [IW-1:0]       base_r, base_nxt;
  logic [HANDLE_W-1:0] rem_r, rem_nxt;
  logic [PW-1:0]       pages_open_r, pages_open_nxt;
  logic [SIZE_W-1:0]   block_size_r;
  logic                pt0_written_r;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [IW-1:0]       grant_r, grant_nxt;
  logic                res_found_r, res_found_nxt;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [HANDLE_W-1:0] out_granted_handle_r;
  logic                out_found_r;
  pt_entry_t           pt_q_r;
  logic [BW-1:0]       link_q_r;

  // Memory port controls.
  logic          pt_rd_en;
  logic          pt_we;
  pt_entry_t     pt_wd;
  logic          link_rd_en;
  logic          link_we;
  logic [BW-1:0] link_wd;
  logic [IW-1:0] link_idx;
  logic [LAW-1:0] link_addr;
  logic          out_load;

  // Current page as seen by the shared unit. Page 0 reads as reset values until its
  // entry is first written; other pages are written when they are opened.
  logic          entry_valid;
  logic [BW-1:0] cur_bump;
  logic [BW-1:0] cur_head;
  logic          page_open;
  logic          hit_bump;
  logic          hit_free;
  logic          in_page;
  logic [PW-1:0] p_inc;

  assign entry_valid = (p_r != '0) || pt0_written_r;
  assign cur_bump    = entry_valid ? pt_q_r.bump : '0;
  assign cur_head    = entry_valid ? pt_q_r.head : BPP_B;
  assign page_open   = p_r < pages_open_r;
  assign hit_bump    = cur_bump < BPP_B;
  assign hit_free    = cur_head < BPP_B;
  assign in_page     = CW'(rem_r) < BPP_C;
  assign p_inc       = p_r + PW'(1);

  // A free links the handle's block; an allocate pops the head block of the page.
  assign link_idx  = (req_type_r == REQ_FREE) ? (base_r + IW'(rem_r))
                                              : (base_r + IW'(cur_head));
  assign link_addr = LAW'(link_idx);

  always_comb begin
    state_nxt      = state_r;
    req_type_nxt   = req_type_r;
    p_nxt          = p_r;
    base_nxt       = base_r;
    rem_nxt        = rem_r;
    pages_open_nxt = pages_open_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    grant_nxt      = grant_r;
    pt_rd_en       = 1'b0;
    pt_we          = 1'b0;
    pt_wd          = '{bump: cur_bump, head: cur_head};
    link_rd_en     = 1'b0;
    link_we        = 1'b0;
    link_wd        = cur_head;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_type_nxt   = in_req_type;
          p_nxt          = '0;
          base_nxt       = '0;
          rem_nxt        = in_handle;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          grant_nxt      = '0;
          pt_rd_en       = 1'b1;
          if ((in_req_type == REQ_ALLOC) && (in_req_size > block_size_r)) begin
            res_status_nxt = ST_TOO_BIG;
            state_nxt      = S_RESP;
          end else if (in_req_type inside {REQ_ALLOC, REQ_FREE, REQ_QUERY}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (!page_open) begin
          // Walked past the last open page.
          state_nxt = S_RESP;
          if (req_type_r == REQ_ALLOC) begin
            if (pages_open_r < MAXP_P) begin
              pages_open_nxt = pages_open_r + PW'(1);
              pt_we          = 1'b1;
              pt_wd          = '{bump: ONE_B, head: BPP_B};
              grant_nxt      = base_r;
            end else begin
              res_status_nxt = ST_NO_PAGES;
            end
          end else if (req_type_r == REQ_FREE) begin
            res_status_nxt = ST_OUTSIDE;
          end
        end else if (req_type_r == REQ_ALLOC) begin
          if (hit_bump) begin
            pt_we     = 1'b1;
            pt_wd     = '{bump: cur_bump + ONE_B, head: cur_head};
            grant_nxt = base_r + IW'(cur_bump);
            state_nxt = S_RESP;
          end else if (hit_free) begin
            link_rd_en = 1'b1;
            grant_nxt  = base_r + IW'(cur_head);
            state_nxt  = S_POP;
          end else begin
            p_nxt    = p_inc;
            base_nxt = base_r + BPP_I;
            pt_rd_en = p_inc < MAXP_P;
          end
        end else begin
          if (in_page) begin
            state_nxt = S_RESP;
            if (req_type_r == REQ_QUERY) begin
              res_found_nxt = 1'b1;
            end else begin
              // Push the block onto its page's free list.
              link_we = 1'b1;
              link_wd = cur_head;
              pt_we   = 1'b1;
              pt_wd   = '{bump: cur_bump, head: BW'(rem_r)};
            end
          end else begin
            p_nxt    = p_inc;
            base_nxt = base_r + BPP_I;
            rem_nxt  = HANDLE_W'(CW'(rem_r) - BPP_C);
            pt_rd_en = p_inc < MAXP_P;
          end
        end
      end
      S_POP: begin
        // Only a full page pops, so its bump count stays at the page size.
        pt_we     = 1'b1;
        pt_wd     = '{bump: BPP_B, head: link_q_r};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Page table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[PIW'(p_r)] <= pt_wd;
    end
    if (pt_rd_en) begin
      pt_q_r <= pt_mem[PIW'(p_nxt)];
    end
  end

  // Link store: written by a free, read by a pop, at the same computed index.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_addr] <= link_wd;
    end
    if (link_rd_en) begin
      link_q_r <= link_mem[link_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pages_open_r  <= PW'(1);
      pt0_written_r <= 1'b0;
      block_size_r  <= BLOCK_SIZE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pages_open_r <= pages_open_nxt;
      if (pt_we && (p_r == '0)) begin
        pt0_written_r <= 1'b1;
      end
      if (cfg_valid) begin
        block_size_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and the result payload.
  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    p_r          <= p_nxt;
    base_r       <= base_nxt;
    rem_r        <= rem_nxt;
    res_status_r <= res_status_nxt;
    grant_r      <= grant_nxt;
    res_found_r  <= res_found_nxt;
    if (out_load) begin
      out_status_r         <= res_status_r;
      out_granted_handle_r <= HANDLE_W'(grant_r);
      out_found_r          <= res_found_r;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_handle = out_granted_handle_r;
  assign out_found          = out_found_r;

endmodule
